/* rtl/core/xbm_pkg.sv */
// Shared constants, codes and helpers for the XBM text bitmap decoder.
// No dependencies; imported by the channel interfaces and the core.
package xbm_pkg;

   localparam int CHAR_W = 8;
   localparam int KIND_W = 2;
   localparam int ERR_W  = 3;
   localparam int BYTE_W = 8;
   localparam int DEFINE_LEN = 7;

   typedef enum logic [KIND_W-1:0] {
      KIND_PIXEL = 2'd0,
      KIND_DIMS  = 2'd1,
      KIND_ERR   = 2'd2
   } kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_LINE_START = 3'd0,
      ERR_WIDTH      = 3'd1,
      ERR_HEIGHT     = 3'd2,
      ERR_EARLY_END  = 3'd3,
      ERR_NO_X       = 3'd4,
      ERR_BAD_HEX    = 3'd5
   } err_type;

   localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF     = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_HASH   = 8'h23;
   localparam logic [CHAR_W-1:0] CHAR_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UP_F   = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_LO_A   = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LO_F   = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_LO_X   = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_LBRACE = 8'h7B;

   // Characters of the "#define" keyword, by position.
   function automatic logic [CHAR_W-1:0] define_char_at(input logic [3:0] idx);
      logic [CHAR_W-1:0] ch;
      unique case (idx)
         4'd0:    ch = CHAR_HASH;
         4'd1:    ch = 8'h64;
         4'd2:    ch = 8'h65;
         4'd3:    ch = 8'h66;
         4'd4:    ch = 8'h69;
         4'd5:    ch = 8'h6E;
         4'd6:    ch = 8'h65;
         default: ch = CHAR_NUL;
      endcase
      return ch;
   endfunction

endpackage

/* rtl/core/xbm_req_if.sv */
// Input channel of the XBM decoder: valid/ready with one text character.
// Depends on xbm_pkg.
interface xbm_req_if import xbm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              end_of_input;

   modport source (output valid, character, end_of_input, input ready);
   modport sink   (input valid, character, end_of_input, output ready);
endinterface

/* rtl/core/xbm_rsp_if.sv */
// Result channel of the XBM decoder: valid/ready with one result item.
// Depends on xbm_pkg.
interface xbm_rsp_if import xbm_pkg::*; #(parameter int DIM_BITS = 16) ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   result_kind;
   logic [BYTE_W-1:0]   pixel_byte;
   logic                last_byte;
   logic [DIM_BITS-1:0] bitmap_width;
   logic [DIM_BITS-1:0] bitmap_height;
   logic [ERR_W-1:0]    error_code;

   modport source (output valid, result_kind, pixel_byte, last_byte, bitmap_width,
                   bitmap_height, error_code, input ready);
   modport sink   (input valid, result_kind, pixel_byte, last_byte, bitmap_width,
                   bitmap_height, error_code, output ready);
endinterface

/* rtl/core/xbm_text_bitmap_decoder_core.sv */
// XBM text bitmap decoder core: parses header and hex body, emits dimensions, pixel bytes and errors.
// Depends on xbm_pkg, xbm_req_if, xbm_rsp_if.
//
// The core takes one text character per clock cycle and never needs more:
// every character is a single update of the parser state, and its result (if
// any) is registered into a two-entry output buffer that drives the result
// channel, so the input keeps accepting while one result waits; input stalls
// only when both entries are full. The image byte count is one multiply of
// the stored dimensions, registered while the parser waits for the opening
// brace.
module xbm_text_bitmap_decoder_core import xbm_pkg::*; #(
   parameter int DIM_BITS = 16
) (
   input logic         clock,
   input logic         reset,
   xbm_req_if.sink     req_chan,
   xbm_rsp_if.source   rsp_chan
);

   localparam int ACC_W   = DIM_BITS + 4;
   localparam int COLS_W  = DIM_BITS - 2;
   localparam int BL_BITS = 2 * DIM_BITS - 3;
   localparam logic [DIM_BITS-1:0] DIM_MAX = {DIM_BITS{1'b1}};

   typedef enum logic [3:0] {
      PH_LINE, PH_SKIPLINE, PH_DEFW, PH_DEFH, PH_BRACE, PH_ZERO,
      PH_X, PH_HI, PH_LO_OK, PH_LO_BAD, PH_DONE, PH_FAIL
   } phase_type;

   typedef enum logic [1:0] {DEF_RUN, DEF_BAD, DEF_END} def_status_type;

   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   pixel;
      logic                last;
      logic [DIM_BITS-1:0] width;
      logic [DIM_BITS-1:0] height;
      err_type             err;
   } result_type;

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic is_line_end(input logic [CHAR_W-1:0] c);
      return (c == CHAR_LF) || (c == CHAR_NUL);
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic [4:0] hex_value(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      logic [4:0] h;
      d = c - CHAR_ZERO;
      h = 5'b10000;
      if (is_digit(c)) begin
         h = {1'b0, d[3:0]};
      end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
         d = c - CHAR_LO_A + 8'd10;
         h = {1'b0, d[3:0]};
      end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
         d = c - CHAR_UP_A + 8'd10;
         h = {1'b0, d[3:0]};
      end
      return h;
   endfunction

   function automatic logic [BYTE_W-1:0] reverse8(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < BYTE_W; i++) begin
         r[i] = v[BYTE_W-1-i];
      end
      return r;
   endfunction

   phase_type            phase_ff, phase_in;
   logic [3:0]           step_ff, step_in;
   logic [DIM_BITS-1:0]  acc_ff, acc_in;
   logic [DIM_BITS-1:0]  width_ff, width_in;
   logic [DIM_BITS-1:0]  height_ff, height_in;
   logic [BL_BITS-1:0]   bytes_ff, bytes_in;
   logic [3:0]           hi_ff, hi_in;
   result_type           out_ff, out_in, skid_ff, skid_in;
   logic                 out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic                 accept, pop, push;
   result_type           res;
   logic [CHAR_W-1:0]    c;
   logic [CHAR_W-1:0]    digit;
   logic [ACC_W-1:0]     acc_next;
   def_status_type       def_status;
   logic [3:0]           def_step;
   logic [DIM_BITS-1:0]  def_acc;
   logic [DIM_BITS:0]    cols_sum;
   logic [COLS_W-1:0]    cols;
   logic [2*DIM_BITS-3:0] total;
   logic [4:0]           hex_c;
   logic [BYTE_W-1:0]    pix_value;
   logic                 is_last;

   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = out_valid_ff && rsp_chan.ready;
   assign c      = req_chan.character;
   assign digit  = c - CHAR_ZERO;
   assign hex_c  = hex_value(c);

   assign cols_sum = {1'b0, width_ff} + (DIM_BITS+1)'(7);
   assign cols     = cols_sum[DIM_BITS:3];
   assign total    = cols * height_ff;

   assign acc_next = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + ACC_W'(digit[3:0]);

   // One character of a define line.
   always_comb begin
      def_status = DEF_RUN;
      def_step   = step_ff;
      def_acc    = acc_ff;
      if (step_ff < 4'(DEFINE_LEN)) begin
         if (c != define_char_at(step_ff)) begin
            def_status = DEF_BAD;
         end else begin
            def_step = step_ff + 4'd1;
         end
      end else begin
         case (step_ff)
            4'd7: begin
               if (is_line_end(c)) def_status = DEF_BAD;
               else if (!is_space(c)) def_step = 4'd8;
            end
            4'd8: begin
               if (is_line_end(c)) def_status = DEF_BAD;
               else if (is_space(c)) def_step = 4'd9;
            end
            4'd9: begin
               if (is_line_end(c)) begin
                  def_status = DEF_BAD;
               end else if (!is_space(c)) begin
                  if (!is_digit(c)) begin
                     def_status = DEF_BAD;
                  end else begin
                     def_acc  = DIM_BITS'(digit[3:0]);
                     def_step = 4'd10;
                  end
               end
            end
            4'd10: begin
               if (is_digit(c)) begin
                  if (acc_next > ACC_W'(DIM_MAX)) def_acc = DIM_MAX;
                  else def_acc = acc_next[DIM_BITS-1:0];
               end else if (c == CHAR_LF) begin
                  def_status = DEF_END;
               end else begin
                  def_step = 4'd11;
               end
            end
            default: begin
               if (c == CHAR_LF) def_status = DEF_END;
            end
         endcase
      end
   end

   // Parser next state and result for the current transfer.
   always_comb begin
      phase_in  = phase_ff;
      step_in   = step_ff;
      acc_in    = acc_ff;
      width_in  = width_ff;
      height_in = height_ff;
      bytes_in  = (phase_ff == PH_BRACE) ? total[BL_BITS-1:0] : bytes_ff;
      hi_in     = hi_ff;
      push      = 1'b0;
      is_last   = (bytes_ff <= BL_BITS'(1));
      pix_value = hex_c[4] ? {4'b0, hi_ff} : {hi_ff, hex_c[3:0]};
      res.kind   = KIND_ERR;
      res.pixel  = '0;
      res.last   = 1'b0;
      res.width  = width_ff;
      res.height = height_ff;
      res.err    = ERR_LINE_START;

      if (accept) begin
         if (req_chan.end_of_input) begin
            push      = (phase_ff != PH_DONE) && (phase_ff != PH_FAIL);
            res.err   = ERR_EARLY_END;
            phase_in  = PH_LINE;
            step_in   = '0;
            acc_in    = '0;
            width_in  = '0;
            height_in = '0;
            bytes_in  = '0;
            hi_in     = '0;
         end else begin
            unique case (phase_ff)
               PH_LINE: begin
                  if (c == CHAR_HASH) begin
                     phase_in = PH_DEFW;
                     step_in  = 4'd1;
                     acc_in   = '0;
                  end else if (c == CHAR_LF) begin
                     phase_in = PH_LINE;
                  end else if (c == CHAR_SLASH || c == CHAR_STAR || is_space(c)) begin
                     phase_in = PH_SKIPLINE;
                  end else begin
                     phase_in = PH_FAIL;
                     push     = 1'b1;
                     res.err  = ERR_LINE_START;
                  end
               end
               PH_SKIPLINE: begin
                  if (c == CHAR_LF) phase_in = PH_LINE;
               end
               PH_DEFW, PH_DEFH: begin
                  step_in = def_step;
                  acc_in  = def_acc;
                  res.err = (phase_ff == PH_DEFW) ? ERR_WIDTH : ERR_HEIGHT;
                  if (def_status == DEF_BAD ||
                      (def_status == DEF_END && acc_ff == '0)) begin
                     phase_in = PH_FAIL;
                     push     = 1'b1;
                  end else if (def_status == DEF_END) begin
                     if (phase_ff == PH_DEFW) begin
                        width_in = acc_ff;
                        acc_in   = '0;
                        step_in  = '0;
                        phase_in = PH_DEFH;
                     end else begin
                        height_in  = acc_ff;
                        phase_in   = PH_BRACE;
                        push       = 1'b1;
                        res.kind   = KIND_DIMS;
                        res.height = acc_ff;
                        res.err    = ERR_LINE_START;
                     end
                  end
               end
               PH_BRACE: begin
                  if (c == CHAR_LBRACE) phase_in = PH_ZERO;
               end
               PH_ZERO: begin
                  if (c == CHAR_ZERO) phase_in = PH_X;
               end
               PH_X: begin
                  if (c != CHAR_LO_X) begin
                     phase_in = PH_FAIL;
                     push     = 1'b1;
                     res.err  = ERR_NO_X;
                  end else begin
                     phase_in = PH_HI;
                  end
               end
               PH_HI: begin
                  hi_in    = hex_c[4] ? 4'd0 : hex_c[3:0];
                  phase_in = hex_c[4] ? PH_LO_BAD : PH_LO_OK;
               end
               PH_LO_BAD: begin
                  phase_in = PH_FAIL;
                  push     = 1'b1;
                  res.err  = ERR_BAD_HEX;
               end
               PH_LO_OK: begin
                  push      = 1'b1;
                  res.kind  = KIND_PIXEL;
                  res.pixel = reverse8(pix_value);
                  res.last  = is_last;
                  res.err   = ERR_LINE_START;
                  if (bytes_ff != '0) bytes_in = bytes_ff - BL_BITS'(1);
                  phase_in  = is_last ? PH_DONE : PH_ZERO;
               end
               PH_DONE, PH_FAIL: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // Two-entry output buffer.
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LINE;
         step_ff       <= '0;
         acc_ff        <= '0;
         width_ff      <= '0;
         height_ff     <= '0;
         bytes_ff      <= '0;
         hi_ff         <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         step_ff       <= step_in;
         acc_ff        <= acc_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         bytes_ff      <= bytes_in;
         hi_ff         <= hi_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_chan.ready         = !skid_valid_ff;
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.result_kind   = out_ff.kind;
   assign rsp_chan.pixel_byte    = out_ff.pixel;
   assign rsp_chan.last_byte     = out_ff.last;
   assign rsp_chan.bitmap_width  = out_ff.width;
   assign rsp_chan.bitmap_height = out_ff.height;
   assign rsp_chan.error_code    = out_ff.err;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without head entry");

   a_eoi_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.end_of_input |=> phase_ff == PH_LINE && width_ff == '0)
      else $error("end of input did not restart the parser");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      push && res.kind == KIND_PIXEL && res.last |=> phase_ff == PH_DONE)
      else $error("final pixel byte did not finish the image");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push |=> out_valid_ff)
      else $error("result transfer lost");

endmodule
